/* sv/spq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    // store size and derived widths
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // fixed port widths
    localparam int REQ_W    = 3;
    localparam int VAL_W    = 16;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 7;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH      = 3'd0,
        REQ_POP       = 3'd1,
        REQ_FIND_PRI  = 3'd2,
        REQ_FIND_DATA = 3'd3,
        REQ_CLEAR     = 3'd4
    } req_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // one stored entry
    typedef struct packed {
        logic signed [VAL_W-1:0] pri;
        logic        [VAL_W-1:0] data;
    } entry_t;

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_PUSH_CMP  = 7'b0000010,
        S_PUSH_FIN  = 7'b0000100,
        S_POP_FRONT = 7'b0001000,
        S_POP_SHIFT = 7'b0010000,
        S_FIND      = 7'b0100000,
        S_DONE      = 7'b1000000
    } state_t;

endpackage : spq_pkg
`default_nettype wire

/* sv/sorted_priority_queue.sv */
`default_nettype none
// Operation: a push moves each later entry up one slot in turn; a pop moves
// each remaining entry down; a find scans the occupied slots, and matches leave
// one per cycle as the scan reaches them, unless a full output stalls the scan.
// Throughput: one request at a time, on the single read and write port of the store.
// Reset: occupancy and control clear at once; the entry store keeps its
// contents and needs no clearing pass, as only slots below occupancy are read.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Sorted list of (priority, data) entries in one synchronous memory, with
// push, pop, find by priority, find by data and clear.
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output      logic                       s_ready,
    input  wire logic [REQ_W-1:0]           s_req_type,
    input  wire logic signed [VAL_W-1:0]    s_priority_value,
    input  wire logic [VAL_W-1:0]           s_data_value,
    output      logic                       m_valid,
    input  wire logic                       m_ready,
    output      logic [STATUS_W-1:0]        m_status,
    output      logic signed [VAL_W-1:0]    m_priority_out,
    output      logic [VAL_W-1:0]           m_data_out,
    output      logic [POS_W-1:0]           m_position,
    output      logic [POS_W-1:0]           m_count,
    output      logic                       m_last
);

    // entry store
    entry_t mem [CAPACITY];
    entry_t rd_data_reg;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // control and request registers
    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        occ_reg, occ_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [REQ_W-1:0]        req_reg, req_next;
    entry_t                  new_reg, new_next;

    // pending result
    logic                    pend_valid_reg, pend_valid_next;
    logic [STATUS_W-1:0]     pend_status_reg, pend_status_next;
    entry_t                  pend_entry_reg, pend_entry_next;
    logic [POS_W-1:0]        pend_pos_reg, pend_pos_next;

    // output register
    logic                    m_valid_reg;
    logic [STATUS_W-1:0]     m_status_reg;
    entry_t                  m_entry_reg;
    logic [POS_W-1:0]        m_position_reg;
    logic [POS_W-1:0]        m_count_reg;
    logic                    m_last_reg;

    logic                    out_free;
    logic                    out_load;
    logic                    out_last;

    logic                    s_xfer;
    logic [CNT_W-1:0]        idx_inc;
    logic [CNT_W-1:0]        idx_dec;
    logic                    goes_before;
    logic                    hit;
    logic                    find_stall;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign idx_dec  = idx_reg - CNT_W'(1);

    // stored entry sits at or before the new one in queue order
    assign goes_before = ($signed(rd_data_reg.pri) < $signed(new_reg.pri)) ||
                         (($signed(rd_data_reg.pri) == $signed(new_reg.pri)) &&
                          (rd_data_reg.data >= new_reg.data));

    // match test for the entry under the find scan
    assign hit = (req_reg == REQ_FIND_PRI) ? (rd_data_reg.pri == new_reg.pri)
                                           : (rd_data_reg.data == new_reg.data);
    assign find_stall = hit && pend_valid_reg && !out_free;

    // sequencer
    always_comb begin
        state_next       = state_reg;
        occ_next         = occ_reg;
        idx_next         = idx_reg;
        req_next         = req_reg;
        new_next         = new_reg;
        pend_valid_next  = pend_valid_reg;
        pend_status_next = pend_status_reg;
        pend_entry_next  = pend_entry_reg;
        pend_pos_next    = pend_pos_reg;
        wr_en            = 1'b0;
        wr_addr          = idx_reg[ADDR_W-1:0];
        wr_data          = new_reg;
        rd_en            = 1'b0;
        rd_addr          = '0;
        out_load         = 1'b0;
        out_last         = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    req_next         = s_req_type;
                    new_next.pri     = s_priority_value;
                    new_next.data    = s_data_value;
                    pend_valid_next  = 1'b0;
                    pend_status_next = ST_OK;
                    pend_entry_next  = '0;
                    pend_pos_next    = '0;
                    case (s_req_type)
                        REQ_PUSH: begin
                            if (occ_reg == CNT_W'(CAPACITY)) begin
                                pend_status_next = ST_FULL;
                                state_next       = S_DONE;
                            end else if (occ_reg == '0) begin
                                idx_next   = '0;
                                state_next = S_PUSH_FIN;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = ADDR_W'(occ_reg - CNT_W'(1));
                                idx_next   = occ_reg;
                                state_next = S_PUSH_CMP;
                            end
                        end
                        REQ_POP: begin
                            if (occ_reg == '0) begin
                                pend_status_next = ST_EMPTY;
                                state_next       = S_DONE;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_POP_FRONT;
                            end
                        end
                        REQ_FIND_PRI, REQ_FIND_DATA: begin
                            if (occ_reg == '0) begin
                                pend_status_next = ST_NOT_FOUND;
                                state_next       = S_DONE;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                idx_next   = '0;
                                state_next = S_FIND;
                            end
                        end
                        REQ_CLEAR: begin
                            occ_next   = '0;
                            state_next = S_DONE;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // shift one entry up per cycle until the slot is found
            S_PUSH_CMP: begin
                wr_en = 1'b1;
                if (goes_before) begin
                    wr_data    = new_reg;
                    occ_next   = occ_reg + CNT_W'(1);
                    state_next = S_DONE;
                end else begin
                    wr_data  = rd_data_reg;
                    idx_next = idx_dec;
                    if (idx_reg == CNT_W'(1)) begin
                        state_next = S_PUSH_FIN;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = ADDR_W'(idx_reg - CNT_W'(2));
                    end
                end
            end

            // new entry goes to the front
            S_PUSH_FIN: begin
                wr_en      = 1'b1;
                wr_data    = new_reg;
                occ_next   = occ_reg + CNT_W'(1);
                state_next = S_DONE;
            end

            // capture the front entry
            S_POP_FRONT: begin
                pend_entry_next = rd_data_reg;
                if (occ_reg == CNT_W'(1)) begin
                    occ_next   = occ_reg - CNT_W'(1);
                    state_next = S_DONE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(1);
                    idx_next   = CNT_W'(1);
                    state_next = S_POP_SHIFT;
                end
            end

            // move each remaining entry down by one
            S_POP_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = idx_dec[ADDR_W-1:0];
                wr_data = rd_data_reg;
                if (idx_inc == occ_reg) begin
                    occ_next   = occ_reg - CNT_W'(1);
                    state_next = S_DONE;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_inc[ADDR_W-1:0];
                    idx_next = idx_inc;
                end
            end

            // scan front to back, holding one match back to mark the last
            S_FIND: begin
                if (!find_stall) begin
                    if (hit) begin
                        if (pend_valid_reg) begin
                            out_load = 1'b1;
                            out_last = 1'b0;
                        end
                        pend_valid_next  = 1'b1;
                        pend_status_next = ST_OK;
                        pend_entry_next  = rd_data_reg;
                        pend_pos_next    = POS_W'(idx_inc);
                    end
                    if (idx_inc == occ_reg) begin
                        if (!hit && !pend_valid_reg) begin
                            pend_status_next = ST_NOT_FOUND;
                        end
                        state_next = S_DONE;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_inc[ADDR_W-1:0];
                        idx_next = idx_inc;
                    end
                end
            end

            // final result of the request
            S_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // store write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            occ_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            occ_reg        <= occ_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        req_reg         <= req_next;
        new_reg         <= new_next;
        pend_status_reg <= pend_status_next;
        pend_entry_reg  <= pend_entry_next;
        pend_pos_reg    <= pend_pos_next;
        if (out_load) begin
            m_status_reg   <= pend_status_reg;
            m_entry_reg    <= pend_entry_reg;
            m_position_reg <= pend_pos_reg;
            m_count_reg    <= POS_W'(occ_reg);
            m_last_reg     <= out_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_priority_out = m_entry_reg.pri;
    assign m_data_out     = m_entry_reg.data;
    assign m_position     = m_position_reg;
    assign m_count        = m_count_reg;
    assign m_last         = m_last_reg;

`ifndef SYNTHESIS
    // occupancy never exceeds the store
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    // a push shift only runs on a non-full store with a slot above the front
    a_push_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PUSH_CMP) |-> (occ_reg < CNT_W'(CAPACITY)) && (idx_reg != '0))
        else $error("push shift out of range");

    // the find scan stays inside the occupied slots
    a_find_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIND) |-> (idx_reg < occ_reg))
        else $error("find scan beyond occupancy");

    // the closing result of a request carries last
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && out_free) |=> (m_valid && m_last))
        else $error("final result without last");
`endif

endmodule : sorted_priority_queue
`default_nettype wire
